// ===== sv/prtc_pkg.sv =====
// Shared types, widths and constants of the playback rate trim controller.
package prtc_pkg;

  localparam int RATIO_W = 17;
  localparam int OCC_W   = 8;
  localparam int DLY_W   = 16;
  localparam int TGT_W   = 7;
  localparam int FPB_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LVL_W   = 17;
  localparam int PROD_W  = GAIN_W + LVL_W;
  localparam int DVSR_W  = 16;
  localparam int CNT_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'd65536;
  localparam logic [RATIO_W-1:0] RATIO_MIN  = 17'd58982;
  localparam logic [RATIO_W-1:0] RATIO_MAX  = 17'd72090;
  localparam logic [RATIO_W-1:0] SMOOTH_MAX = 17'd131071;
  // Both clamp limits sit the same distance from 1.0
  localparam logic [PROD_W-1:0]  TRIM_LIMIT = 33'd6554;
  localparam logic [OCC_W-1:0]   QUEUE_DEPTH = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BUFFER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPORTIONAL_GAIN = 2'd2;

  localparam logic [TGT_W-1:0]  TARGET_LEVEL_RST      = 7'd50;
  localparam logic [FPB_W-1:0]  FRAMES_PER_BUFFER_RST = 16'd441;
  localparam logic [GAIN_W-1:0] PROPORTIONAL_GAIN_RST = 16'd6554;

  typedef struct packed {
    logic [OCC_W-1:0] queue_occupancy;
    logic [DLY_W-1:0] driver_delay_frames;
    logic             playing_started;
  } in_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] smoothed_ratio;
    logic [RATIO_W-1:0] raw_ratio;
    logic               was_clamped;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DVSR_W-1:0] divisor;
    logic [CNT_W-1:0]  count;
  } div_req_t;

  typedef struct packed {
    logic              start;
    logic [GAIN_W-1:0] gain;
    logic [LVL_W-1:0]  mcand;
  } mul_req_t;

endpackage

// ===== sv/prtc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, dividend left-aligned.
module prtc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  prtc_pkg::div_req_t              req,
  output logic                            done,
  output logic [prtc_pkg::PROD_W-1:0]     quotient
);

  logic                            busy;
  logic [prtc_pkg::CNT_W-1:0]      cnt;
  logic [prtc_pkg::PROD_W-1:0]     dvd;
  logic [prtc_pkg::DVSR_W-1:0]     dvsr;
  logic [prtc_pkg::DVSR_W-1:0]     rem;
  logic [prtc_pkg::DVSR_W-1:0]     rem_next;
  logic [prtc_pkg::DVSR_W:0]       rem_sh;
  logic [prtc_pkg::DVSR_W:0]       rem_dif;
  logic                            fits;

  always_comb begin
    rem_sh   = {rem, dvd[prtc_pkg::PROD_W-1]};
    rem_dif  = rem_sh - {1'b0, dvsr};
    fits     = (rem_sh >= {1'b0, dvsr});
    rem_next = fits ? rem_dif[prtc_pkg::DVSR_W-1:0] : rem_sh[prtc_pkg::DVSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - prtc_pkg::CNT_W'(1);
        if (cnt == prtc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd      <= req.dividend;
      dvsr     <= req.divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[prtc_pkg::PROD_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[prtc_pkg::PROD_W-2:0], fits};
    end
  end

endmodule

// ===== sv/prtc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplicand bit per cycle, MSB first.
module prtc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  prtc_pkg::mul_req_t          req,
  output logic                        done,
  output logic [prtc_pkg::PROD_W-1:0] product
);

  logic                            busy;
  logic [prtc_pkg::CNT_W-1:0]      cnt;
  logic [prtc_pkg::GAIN_W-1:0]     gain;
  logic [prtc_pkg::LVL_W-1:0]      mcand;
  logic [prtc_pkg::PROD_W-1:0]     addend;

  assign addend = mcand[prtc_pkg::LVL_W-1] ? prtc_pkg::PROD_W'(gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= prtc_pkg::CNT_W'(prtc_pkg::LVL_W);
      end else if (busy) begin
        cnt <= cnt - prtc_pkg::CNT_W'(1);
        if (cnt == prtc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      gain    <= req.gain;
      mcand   <= req.mcand;
      product <= '0;
    end else if (busy) begin
      mcand   <= {mcand[prtc_pkg::LVL_W-2:0], 1'b0};
      product <= {product[prtc_pkg::PROD_W-2:0], 1'b0} + addend;
    end
  end

endmodule

// ===== sv/prtc_ring.sv =====
// Ratio history ring in memory with its running sum.
module prtc_ring #(
  parameter int AVERAGE_LENGTH = 128,
  localparam int SUM_W = prtc_pkg::RATIO_W + $clog2(AVERAGE_LENGTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [prtc_pkg::RATIO_W-1:0]  raw,
  output logic                          done,
  output logic [SUM_W-1:0]              sum
);

  localparam int AW = $clog2(AVERAGE_LENGTH);
  localparam logic [SUM_W-1:0] SUM_INIT =
    SUM_W'(AVERAGE_LENGTH) * SUM_W'(prtc_pkg::RATIO_ONE);

  logic [prtc_pkg::RATIO_W-1:0] hist [AVERAGE_LENGTH];
  logic [prtc_pkg::RATIO_W-1:0] old;
  logic [AW-1:0]                wi;
  logic [AW-1:0]                wi_next;
  logic                         full;
  logic                         pending;

  assign wi_next = (wi == AW'(AVERAGE_LENGTH - 1)) ? '0 : wi + AW'(1);

  // Write the new entry and fetch the one after it in the same cycle
  always_ff @(posedge clk) begin
    if (push) begin
      hist[wi] <= raw;
      old      <= hist[wi_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi      <= '0;
      full    <= 1'b0;
      pending <= 1'b0;
      done    <= 1'b0;
      sum     <= SUM_INIT;
    end else begin
      pending <= push;
      done    <= pending;
      if (push) begin
        sum <= sum + SUM_W'(raw);
        wi  <= wi_next;
        if (wi_next == '0) begin
          full <= 1'b1;
        end
      end else if (pending) begin
        // Entries not yet written since reset count as 1.0
        sum <= sum - (full ? SUM_W'(old) : SUM_W'(prtc_pkg::RATIO_ONE));
      end
    end
  end

endmodule

// ===== sv/playback_rate_trim_controller.sv =====
// Playback rate trim controller: sequencer, configuration registers and output register.
//
// Usage: one input item per audio buffer on in_data (in_valid / in_stall) carries
// the queue occupancy, the driver delay in frames and the started flag. One result
// item per input comes out on out_data (out_valid / out_stall) with the smoothed
// ratio, the clamped raw ratio and the clamp flag. Registers are to be written by the
// user on the cfg_* channel (cfg_ready is always high) only while no item is in flight;
// the block itself does not enforce this. An item with playback running goes through
// the level division, the multiplier, the magnitude division, the ring update and the
// average division; when not started it only updates the ring and runs the average
// division. A new item is accepted in the cycle after the previous one has reached the
// output register. The shared bit-serial divider, one quotient bit per cycle, does the
// divisions: driver delay over buffer length, the scaled error over the target, and
// the running sum over the history length.
// Reset (rst, synchronous) restores the register defaults, fills the history with
// 1.0 by means of a fill flag and empties the output register. A stalled result holds
// in the output register; the next item may be accepted meanwhile and waits for it
// at the end of its own work.
module playback_rate_trim_controller #(
  parameter int AVERAGE_LENGTH = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  prtc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output prtc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prtc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = prtc_pkg::RATIO_W + $clog2(AVERAGE_LENGTH);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DIV_LVL = 7'b0000010,
    S_MUL     = 7'b0000100,
    S_DIV_MAG = 7'b0001000,
    S_RING    = 7'b0010000,
    S_DIV_AVG = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [prtc_pkg::TGT_W-1:0]   target_level;
  logic [prtc_pkg::FPB_W-1:0]   frames_per_buffer;
  logic [prtc_pkg::GAIN_W-1:0]  proportional_gain;

  logic [prtc_pkg::OCC_W-1:0]   occ_sat;
  logic                         level_above;
  logic [prtc_pkg::RATIO_W-1:0] raw_hold;
  logic                         clamp_hold;

  logic                         in_take;
  logic                         load;
  logic [prtc_pkg::TGT_W-1:0]   tgt_eff;
  logic [prtc_pkg::LVL_W-1:0]   level;
  logic [prtc_pkg::LVL_W-1:0]   diff;
  logic                         above;
  logic                         mag_big;
  logic [prtc_pkg::RATIO_W-1:0] mag;
  logic [prtc_pkg::RATIO_W-1:0] raw_calc;
  logic [prtc_pkg::RATIO_W-1:0] smoothed;

  prtc_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [prtc_pkg::PROD_W-1:0]  div_q;
  prtc_pkg::mul_req_t           mul_req;
  logic                         mul_done;
  logic [prtc_pkg::PROD_W-1:0]  product;
  logic                         ring_push;
  logic [prtc_pkg::RATIO_W-1:0] ring_raw;
  logic                         ring_done;
  logic [SUM_W-1:0]             ring_sum;

  prtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  prtc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (product)
  );

  prtc_ring #(
    .AVERAGE_LENGTH (AVERAGE_LENGTH)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .push (ring_push),
    .raw  (ring_raw),
    .done (ring_done),
    .sum  (ring_sum)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign load      = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    tgt_eff  = (target_level == '0) ? prtc_pkg::TGT_W'(1) : target_level;
    level    = prtc_pkg::LVL_W'(occ_sat) + prtc_pkg::LVL_W'(div_q[prtc_pkg::DLY_W-1:0]);
    above    = level > prtc_pkg::LVL_W'(tgt_eff);
    diff     = above ? level - prtc_pkg::LVL_W'(tgt_eff) : prtc_pkg::LVL_W'(tgt_eff) - level;
    mag_big  = div_q > prtc_pkg::TRIM_LIMIT;
    mag      = div_q[prtc_pkg::RATIO_W-1:0];
    if (level_above) begin
      raw_calc = mag_big ? prtc_pkg::RATIO_MIN : prtc_pkg::RATIO_ONE - mag;
    end else begin
      raw_calc = mag_big ? prtc_pkg::RATIO_MAX : prtc_pkg::RATIO_ONE + mag;
    end
    smoothed = (|div_q[prtc_pkg::PROD_W-1:prtc_pkg::RATIO_W]) ? prtc_pkg::SMOOTH_MAX
                                                              : div_q[prtc_pkg::RATIO_W-1:0];
  end

  // Route the shared divider, the multiplier and the ring from the sequencer
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = prtc_pkg::DVSR_W'(1);
    div_req.count    = '0;
    mul_req.start    = 1'b0;
    mul_req.gain     = proportional_gain;
    mul_req.mcand    = diff;
    ring_push        = 1'b0;
    ring_raw         = prtc_pkg::RATIO_ONE;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.playing_started) begin
            div_req.start = 1'b1;
            div_req.count = prtc_pkg::CNT_W'(prtc_pkg::DLY_W);
            // A zero buffer length drops the driver term: divide zero by one
            if (frames_per_buffer != '0) begin
              div_req.dividend = {in_data.driver_delay_frames,
                                  {(prtc_pkg::PROD_W - prtc_pkg::DLY_W){1'b0}}};
              div_req.divisor  = frames_per_buffer;
            end
          end else begin
            ring_push = 1'b1;
          end
        end
      end
      S_DIV_LVL: begin
        mul_req.start = div_done;
      end
      S_MUL: begin
        if (mul_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = product;
          div_req.divisor  = prtc_pkg::DVSR_W'(tgt_eff);
          div_req.count    = prtc_pkg::CNT_W'(prtc_pkg::PROD_W);
        end
      end
      S_DIV_MAG: begin
        ring_push = div_done;
        ring_raw  = raw_calc;
      end
      S_RING: begin
        if (ring_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {ring_sum, {(prtc_pkg::PROD_W - SUM_W){1'b0}}};
          div_req.divisor  = prtc_pkg::DVSR_W'(AVERAGE_LENGTH);
          div_req.count    = prtc_pkg::CNT_W'(SUM_W);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = in_data.playing_started ? S_DIV_LVL : S_RING;
        end
      end
      S_DIV_LVL: begin
        if (div_done) state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_done) state_next = S_DIV_MAG;
      end
      S_DIV_MAG: begin
        if (div_done) state_next = S_RING;
      end
      S_RING: begin
        if (ring_done) state_next = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      target_level      <= prtc_pkg::TARGET_LEVEL_RST;
      frames_per_buffer <= prtc_pkg::FRAMES_PER_BUFFER_RST;
      proportional_gain <= prtc_pkg::PROPORTIONAL_GAIN_RST;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prtc_pkg::CFG_TARGET_LEVEL:      target_level      <= cfg_data[prtc_pkg::TGT_W-1:0];
          prtc_pkg::CFG_FRAMES_PER_BUFFER: frames_per_buffer <= cfg_data;
          prtc_pkg::CFG_PROPORTIONAL_GAIN: proportional_gain <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      occ_sat    <= (in_data.queue_occupancy > prtc_pkg::QUEUE_DEPTH) ? prtc_pkg::QUEUE_DEPTH
                                                                     : in_data.queue_occupancy;
      raw_hold   <= prtc_pkg::RATIO_ONE;
      clamp_hold <= 1'b0;
    end
    if ((state == S_DIV_LVL) && div_done) begin
      level_above <= above;
    end
    if ((state == S_DIV_MAG) && div_done) begin
      raw_hold   <= raw_calc;
      clamp_hold <= mag_big;
    end
    if (load) begin
      out_data.smoothed_ratio <= smoothed;
      out_data.raw_ratio      <= raw_hold;
      out_data.was_clamped    <= clamp_hold;
    end
  end

endmodule

// ===== sv/prtc_checker.sv =====
// Port-level checks of the playback rate trim controller, bound to the top level.
module prtc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input prtc_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_stall
);

  // One item at a time: after taking an item the input holds off
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after an item");

  a_raw_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.raw_ratio >= prtc_pkg::RATIO_MIN) &&
                  (out_data.raw_ratio <= prtc_pkg::RATIO_MAX))
    else $error("raw ratio outside the clamp limits");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_clamped |->
      (out_data.raw_ratio == prtc_pkg::RATIO_MIN) || (out_data.raw_ratio == prtc_pkg::RATIO_MAX))
    else $error("clamp flag set with raw ratio off the limits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind playback_rate_trim_controller prtc_checker u_prtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// ===== sim/tb_playback_rate_trim_controller.sv =====
// Self-checking testbench of the playback rate trim controller.
`timescale 1ns / 100ps

module tb_playback_rate_trim_controller;

  localparam int AVG_LEN     = 128;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SEGMENTS    = 14;
  localparam int SEG_ITEMS   = 100;
  localparam int SETTLE      = 150;
  localparam logic [prtc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [prtc_pkg::CFG_IDX_W-1:0]  idx;
    logic [prtc_pkg::CFG_DATA_W-1:0] data;
    prtc_pkg::in_item_t              item;
    bit                              typed;
    prtc_pkg::out_item_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  prtc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  prtc_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Trim predictor state
  logic [prtc_pkg::RATIO_W-1:0] trim_history [AVG_LEN];
  longint unsigned              trim_sum;
  int                           trim_wr_ptr;
  logic [prtc_pkg::TGT_W-1:0]   cur_target;
  logic [prtc_pkg::FPB_W-1:0]   cur_fpb;
  logic [prtc_pkg::GAIN_W-1:0]  cur_gain;

  prtc_pkg::out_item_t ratio_expect_q[$];
  stim_row_t dir_rows[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int stopped_sent = 0;
  int results_seen = 0;
  int clamped_seen = 0;
  int regs_written = 0;

  playback_rate_trim_controller #(.AVERAGE_LENGTH(AVG_LEN)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compute the trimmed and smoothed ratio for one item and advance the history
  function automatic prtc_pkg::out_item_t predict_trim(input prtc_pkg::in_item_t it);
    longint unsigned occ, tgt, level, mag, r, avg;
    prtc_pkg::out_item_t res;
    bit clip;
    clip = 1'b0;
    r = prtc_pkg::RATIO_ONE;
    if (it.playing_started) begin
      occ = (it.queue_occupancy > prtc_pkg::QUEUE_DEPTH) ? prtc_pkg::QUEUE_DEPTH
                                                         : it.queue_occupancy;
      tgt = (cur_target == 0) ? 1 : cur_target;
      level = occ;
      if (cur_fpb != 0) level += it.driver_delay_frames / cur_fpb;
      if (level <= tgt) begin
        mag = (longint'(cur_gain) * (tgt - level)) / tgt;
        r = prtc_pkg::RATIO_ONE + mag;
        if (r > prtc_pkg::RATIO_MAX) begin
          r = prtc_pkg::RATIO_MAX;
          clip = 1'b1;
        end
      end else begin
        mag = (longint'(cur_gain) * (level - tgt)) / tgt;
        if (mag > prtc_pkg::RATIO_ONE - prtc_pkg::RATIO_MIN) begin
          r = prtc_pkg::RATIO_MIN;
          clip = 1'b1;
        end else begin
          r = prtc_pkg::RATIO_ONE - mag;
        end
      end
    end
    // The entry dropped is the one after the slot just written
    trim_history[trim_wr_ptr] = prtc_pkg::RATIO_W'(r);
    trim_sum += r;
    trim_wr_ptr = (trim_wr_ptr + 1) % AVG_LEN;
    trim_sum -= trim_history[trim_wr_ptr];
    avg = trim_sum / AVG_LEN;
    if (avg > prtc_pkg::SMOOTH_MAX) avg = prtc_pkg::SMOOTH_MAX;
    res.smoothed_ratio = prtc_pkg::RATIO_W'(avg);
    res.raw_ratio = prtc_pkg::RATIO_W'(r);
    res.was_clamped = clip;
    return res;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [prtc_pkg::RATIO_W-1:0] want,
                                      input logic [prtc_pkg::RATIO_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void add_item(input int occ, input int dly, input bit st);
    stim_row_t row;
    row = '{kind: ROW_ITEM, idx: '0, data: '0, item: '0, typed: 1'b0, want: '0};
    row.item.queue_occupancy = prtc_pkg::OCC_W'(occ);
    row.item.driver_delay_frames = prtc_pkg::DLY_W'(dly);
    row.item.playing_started = st;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(input int occ, input int dly, input bit st,
                                    input int sm, input int raw, input bit cl);
    add_item(occ, dly, st);
    dir_rows[$].typed = 1'b1;
    dir_rows[$].want = '{smoothed_ratio: prtc_pkg::RATIO_W'(sm),
                         raw_ratio: prtc_pkg::RATIO_W'(raw), was_clamped: cl};
  endfunction

  function automatic void add_cfg(input logic [prtc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [prtc_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, item: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  // Offer one item, hold it until taken, then queue its expected result
  task automatic push_item(input prtc_pkg::in_item_t it, input bit typed,
                           input prtc_pkg::out_item_t want);
    prtc_pkg::out_item_t guess;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = predict_trim(it);
    ratio_expect_q.push_back(typed ? want : guess);
    items_sent++;
    if (!it.playing_started) stopped_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ratio_expect_q.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(input logic [prtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prtc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      prtc_pkg::CFG_TARGET_LEVEL:      cur_target = data[prtc_pkg::TGT_W-1:0];
      prtc_pkg::CFG_FRAMES_PER_BUFFER: cur_fpb = data[prtc_pkg::FPB_W-1:0];
      prtc_pkg::CFG_PROPORTIONAL_GAIN: cur_gain = data[prtc_pkg::GAIN_W-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Result checker and progress watchdog
  always @(posedge clk) begin
    prtc_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (ratio_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, got %p", $time, out_data);
        end else begin
          want = ratio_expect_q.pop_front();
          check_field("smoothed_ratio", want.smoothed_ratio, out_data.smoothed_ratio);
          check_field("raw_ratio", want.raw_ratio, out_data.raw_ratio);
          check_field("was_clamped", prtc_pkg::RATIO_W'(want.was_clamped),
                      prtc_pkg::RATIO_W'(out_data.was_clamped));
          results_seen++;
          if (out_data.was_clamped === 1'b1) clamped_seen++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, ratio_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    prtc_pkg::in_item_t it;
    int tgt_eff, lvl, occ_i, k;
    longint unsigned dly;
    bit st;
    logic [prtc_pkg::CFG_DATA_W-1:0] t_val, f_val, g_val;

    cur_target = prtc_pkg::TARGET_LEVEL_RST;
    cur_fpb = prtc_pkg::FRAMES_PER_BUFFER_RST;
    cur_gain = prtc_pkg::PROPORTIONAL_GAIN_RST;
    foreach (trim_history[i]) trim_history[i] = prtc_pkg::RATIO_ONE;
    trim_sum = longint'(AVG_LEN) * prtc_pkg::RATIO_ONE;
    trim_wr_ptr = 0;

    // Directed rows: extremes at reset settings, then each register edge case
    add_typed(0, 0, 1'b0, 65536, 65536, 1'b0);
    add_typed(255, 65535, 1'b0, 65536, 65536, 1'b0);
    add_typed(255, 65535, 1'b1, 65484, 58982, 1'b1);
    add_typed(0, 0, 1'b1, 65536, 72090, 1'b0);
    add_item(50, 0, 1'b1);
    add_item(51, 0, 1'b1);
    add_item(128, 0, 1'b1);
    add_item(129, 0, 1'b1);
    add_item(0, 440, 1'b1);
    add_item(0, 441, 1'b1);
    add_item(49, 441, 1'b1);
    add_cfg(CFG_UNUSED_IDX, 16'hFFFF);
    add_item(30, 8820, 1'b1);
    add_cfg(prtc_pkg::CFG_TARGET_LEVEL, 16'h0080);
    add_item(0, 0, 1'b1);
    add_item(1, 0, 1'b1);
    add_item(2, 0, 1'b1);
    add_item(3, 0, 1'b1);
    add_cfg(prtc_pkg::CFG_FRAMES_PER_BUFFER, 16'd0);
    add_cfg(prtc_pkg::CFG_PROPORTIONAL_GAIN, 16'hFFFF);
    add_item(0, 65535, 1'b1);
    add_item(1, 65535, 1'b1);
    add_cfg(prtc_pkg::CFG_PROPORTIONAL_GAIN, 16'd0);
    add_cfg(prtc_pkg::CFG_TARGET_LEVEL, 16'd127);
    add_cfg(prtc_pkg::CFG_FRAMES_PER_BUFFER, 16'hFFFF);
    add_item(255, 65535, 1'b1);
    add_item(0, 0, 1'b1);
    add_cfg(prtc_pkg::CFG_PROPORTIONAL_GAIN, 16'hFFFF);
    add_item(127, 65535, 1'b1);
    add_item(126, 0, 1'b1);
    add_item(0, 65535, 1'b0);
    add_cfg(prtc_pkg::CFG_TARGET_LEVEL, prtc_pkg::CFG_DATA_W'(prtc_pkg::TARGET_LEVEL_RST));
    add_cfg(prtc_pkg::CFG_FRAMES_PER_BUFFER, prtc_pkg::FRAMES_PER_BUFFER_RST);
    add_cfg(prtc_pkg::CFG_PROPORTIONAL_GAIN, prtc_pkg::PROPORTIONAL_GAIN_RST);
    add_item(60, 882, 1'b1);

    tx_idle_pct = 14;
    rx_stall_pct = 88;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        tx_idle_pct = 14;
        rx_stall_pct = 88;
      end else if (seg < 10) begin
        tx_idle_pct = 88;
        rx_stall_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end

      // Settle the block before changing its settings
      drain_results();
      case (seg % 4)
        0: begin
          t_val = prtc_pkg::CFG_DATA_W'($urandom_range(1, 127));
          f_val = prtc_pkg::CFG_DATA_W'($urandom_range(64, 1024));
          g_val = prtc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        end
        1: begin
          t_val = $urandom_range(0, 1) ? 16'd127 : 16'd1;
          f_val = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
          g_val = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        end
        2: begin
          t_val = prtc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          f_val = prtc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          g_val = prtc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        end
        default: begin
          t_val = prtc_pkg::CFG_DATA_W'($urandom_range(20, 80)) |
                  (prtc_pkg::CFG_DATA_W'($urandom_range(0, 511)) << prtc_pkg::TGT_W);
          f_val = prtc_pkg::CFG_DATA_W'($urandom_range(256, 512));
          g_val = prtc_pkg::CFG_DATA_W'($urandom_range(2000, 20000));
        end
      endcase
      write_reg(prtc_pkg::CFG_TARGET_LEVEL, t_val);
      write_reg(prtc_pkg::CFG_FRAMES_PER_BUFFER, f_val);
      write_reg(prtc_pkg::CFG_PROPORTIONAL_GAIN, g_val);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_UNUSED_IDX, prtc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;

      for (int n = 0; n < SEG_ITEMS; n++) begin
        tgt_eff = (cur_target == 0) ? 1 : cur_target;
        if ($urandom_range(0, 3) != 0) begin
          // Aim the backlog near the target so the controller works unclamped
          lvl = tgt_eff + int'($urandom_range(0, 24)) - 12;
          if (lvl < 0) lvl = 0;
          occ_i = $urandom_range(0, (lvl > 128) ? 128 : lvl);
          k = lvl - occ_i;
          if (cur_fpb == 0)
            dly = $urandom_range(0, 65535);
          else
            dly = longint'(k) * cur_fpb + $urandom_range(0, cur_fpb - 1);
          if (dly > 65535) dly = $urandom_range(0, 65535);
          st = ($urandom_range(0, 9) != 0);
        end else begin
          occ_i = $urandom_range(0, 255);
          dly = $urandom_range(0, 65535);
          st = 1'($urandom_range(0, 1));
        end
        it.queue_occupancy = prtc_pkg::OCC_W'(occ_i);
        it.driver_delay_frames = prtc_pkg::DLY_W'(dly);
        it.playing_started = st;
        if (seg == 11 && n == 40) hold_request = 1'b1;
        push_item(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d items (%0d with playback stopped), %0d results, %0d clamped",
             items_sent, stopped_sent, results_seen, clamped_seen);
    $display("%0d register writes, %0d mismatches, %0d results missing",
             regs_written, mismatches, ratio_expect_q.size());
    if (mismatches == 0 && ratio_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
